[rtl/mwf_pkg.sv]
package mwf_pkg;

	// Width of one map entry: one wall bit per absolute side.
	localparam int WALL_W = 4;

	// Absolute sides and headings.
	localparam logic [1:0] HEAD_NORTH = 2'd0;
	localparam logic [1:0] HEAD_EAST  = 2'd1;
	localparam logic [1:0] HEAD_SOUTH = 2'd2;
	localparam logic [1:0] HEAD_WEST  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GOAL_X       = 2'd0;
	localparam logic [1:0] CFG_GOAL_Y       = 2'd1;
	localparam logic [1:0] CFG_FOLLOW_RIGHT = 2'd2;

	// Move decision reported with each result.
	typedef enum logic [2:0] {
		ACT_LEFT  = 3'd0,
		ACT_FWD   = 3'd1,
		ACT_RIGHT = 3'd2,
		ACT_BACK  = 3'd3,
		ACT_STOP  = 3'd4
	} action_t;

endpackage

[rtl/mwf_wall_mem.sv]
module mwf_wall_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [mwf_pkg::WALL_W-1:0] wdata,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [mwf_pkg::WALL_W-1:0] rdata,
	output logic                       busy
);

	logic [mwf_pkg::WALL_W-1:0] mem [DEPTH];

	logic                       clr_q;
	logic [ADDR_W-1:0]          clr_addr_q;
	logic                       w_en;
	logic [ADDR_W-1:0]          w_addr;
	logic [mwf_pkg::WALL_W-1:0] w_data;
	logic [mwf_pkg::WALL_W-1:0] rd_raw_q;
	logic [mwf_pkg::WALL_W-1:0] byp_data_q;
	logic                       byp_q;

	// The clearing pass owns the write port until every entry is zero.
	always_comb begin
		w_en   = clr_q | we;
		w_addr = clr_q ? clr_addr_q : waddr;
		w_data = clr_q ? '0 : wdata;
	end

	// Sweep one entry per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Single write port, one registered read port.
	always_ff @(posedge clk) begin
		if (w_en) begin
			mem[w_addr] <= w_data;
		end
		rd_raw_q <= mem[raddr];
	end

	// A write to the address being read in the same cycle is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q      <= 1'b0;
			byp_data_q <= '0;
		end else begin
			byp_q      <= w_en && (w_addr == raddr);
			byp_data_q <= w_data;
		end
	end

	assign rdata = byp_q ? byp_data_q : rd_raw_q;
	assign busy  = clr_q;

endmodule

[rtl/maze_wall_follower_step.sv]
// Wall-following step controller for a maze robot.
// Input stream (s_*): one transaction per sensed cell carrying the left, front and
// right wall sensor bits. Output stream (m_*): one transaction per input with the
// chosen move, the new position and heading, the updated walls of the sensed cell
// and the at-goal and off-grid flags.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 goal column,
// 1 goal row, 2 follow-right select) at the clock edge; write only while idle.
// The result is registered: it is valid the cycle after the input is taken.
// One item is taken per cycle while the map is not being cleared and the
// receiver is ready. The current cell's map entry is read ahead, addressed by
// the position the robot will hold next, so the wall read-modify-write and
// the move decision fit between the read register and the result register.
// After reset the wall map is cleared one entry per cycle, all GRID_SIDE*GRID_SIDE
// entries (256 at the default size); s_tready stays low during that pass.
// Reset also puts the robot at column 0, row 0, heading north.
// When the receiver stalls, the result register holds and one new item is taken
// only as the held result leaves.
module maze_wall_follower_step #(
	parameter int GRID_SIDE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] sense_left, [1] sense_front, [2] sense_right, [7:3] zero
	input  logic [7:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] action, [6:3] pos_x, [10:7] pos_y, [12:11] heading,
	// [16:13] cell_walls, [17] at_goal, [18] off_grid, [23:19] zero
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int POS_W     = $clog2(GRID_SIDE);
	localparam int MAP_CELLS = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W    = $clog2(MAP_CELLS);
	localparam int CMP_W     = (POS_W > 4) ? POS_W : 4;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(GRID_SIDE - 1);

	// Configuration registers.
	logic [3:0] goal_x_q;
	logic [3:0] goal_y_q;
	logic       follow_right_q;

	// Robot state.
	logic [POS_W-1:0] cur_x_q;
	logic [POS_W-1:0] cur_y_q;
	logic [1:0]       heading_q;

	// Result register.
	logic                       out_valid_q;
	mwf_pkg::action_t           out_action_q;
	logic [3:0]                 out_x_q;
	logic [3:0]                 out_y_q;
	logic [1:0]                 out_heading_q;
	logic [mwf_pkg::WALL_W-1:0] out_walls_q;
	logic                       out_goal_q;
	logic                       out_off_q;

	logic                       s_acc;
	logic                       mem_busy;
	logic                       wl;
	logic                       wf;
	logic                       wr;
	logic [mwf_pkg::WALL_W-1:0] cell_old;
	logic [mwf_pkg::WALL_W-1:0] sensed;
	logic [mwf_pkg::WALL_W-1:0] cell_new;
	logic                       at_goal;
	mwf_pkg::action_t           act;
	logic [1:0]                 h_next;
	logic [POS_W-1:0]           nx;
	logic [POS_W-1:0]           ny;
	logic                       off;
	logic [CMP_W-1:0]           nx_ext;
	logic [CMP_W-1:0]           ny_ext;
	logic [POS_W-1:0]           rd_x;
	logic [POS_W-1:0]           rd_y;
	logic [ADDR_W-1:0]          cur_addr;
	logic [ADDR_W-1:0]          rd_addr;

	assign s_tready = !mem_busy && (!out_valid_q || m_tready);
	assign s_acc    = s_tvalid && s_tready;

	assign wl = s_tdata[0];
	assign wf = s_tdata[1];
	assign wr = s_tdata[2];

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q       <= '0;
			goal_y_q       <= '0;
			follow_right_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwf_pkg::CFG_GOAL_X:       goal_x_q       <= cfg_data;
				mwf_pkg::CFG_GOAL_Y:       goal_y_q       <= cfg_data;
				mwf_pkg::CFG_FOLLOW_RIGHT: follow_right_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Map the relative sensor bits onto absolute sides and merge them in.
	always_comb begin
		for (int side = 0; side < mwf_pkg::WALL_W; side++) begin
			sensed[side] = (wf && (2'(side) == heading_q))
				|| (wl && (2'(side) == heading_q + 2'd3))
				|| (wr && (2'(side) == heading_q + 2'd1));
		end
		cell_new = cell_old | sensed;
	end

	assign at_goal = (CMP_W'(cur_x_q) == CMP_W'(goal_x_q))
		&& (CMP_W'(cur_y_q) == CMP_W'(goal_y_q));

	// Stop on the goal; otherwise pick the first open way in the wall-following order.
	always_comb begin
		if (at_goal) begin
			act = mwf_pkg::ACT_STOP;
		end else if (follow_right_q) begin
			priority if (!wr) act = mwf_pkg::ACT_RIGHT;
			else if (!wf)     act = mwf_pkg::ACT_FWD;
			else if (!wl)     act = mwf_pkg::ACT_LEFT;
			else              act = mwf_pkg::ACT_BACK;
		end else begin
			priority if (!wl) act = mwf_pkg::ACT_LEFT;
			else if (!wf)     act = mwf_pkg::ACT_FWD;
			else if (!wr)     act = mwf_pkg::ACT_RIGHT;
			else              act = mwf_pkg::ACT_BACK;
		end
	end

	// Turn, then step one cell unless that leaves the grid.
	always_comb begin
		unique case (act)
			mwf_pkg::ACT_LEFT:  h_next = heading_q + 2'd3;
			mwf_pkg::ACT_RIGHT: h_next = heading_q + 2'd1;
			mwf_pkg::ACT_BACK:  h_next = heading_q + 2'd2;
			default:            h_next = heading_q;
		endcase
		nx  = cur_x_q;
		ny  = cur_y_q;
		off = 1'b0;
		if (!at_goal) begin
			unique case (h_next)
				mwf_pkg::HEAD_NORTH: begin
					if (cur_y_q != POS_MAX) ny = cur_y_q + 1'b1;
					else off = 1'b1;
				end
				mwf_pkg::HEAD_EAST: begin
					if (cur_x_q != POS_MAX) nx = cur_x_q + 1'b1;
					else off = 1'b1;
				end
				mwf_pkg::HEAD_SOUTH: begin
					if (cur_y_q != '0) ny = cur_y_q - 1'b1;
					else off = 1'b1;
				end
				default: begin
					if (cur_x_q != '0) nx = cur_x_q - 1'b1;
					else off = 1'b1;
				end
			endcase
		end
		nx_ext = CMP_W'(nx);
		ny_ext = CMP_W'(ny);
	end

	// Map addresses: write at the current cell, read ahead at the next one.
	always_comb begin
		rd_x     = s_acc ? nx : cur_x_q;
		rd_y     = s_acc ? ny : cur_y_q;
		cur_addr = ADDR_W'(cur_y_q * GRID_SIDE + cur_x_q);
		rd_addr  = ADDR_W'(rd_y * GRID_SIDE + rd_x);
	end

	mwf_wall_mem #(
		.DEPTH  (MAP_CELLS),
		.ADDR_W (ADDR_W)
	) u_wall_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (s_acc),
		.waddr  (cur_addr),
		.wdata  (cell_new),
		.raddr  (rd_addr),
		.rdata  (cell_old),
		.busy   (mem_busy)
	);

	// Robot state advances with each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			heading_q <= mwf_pkg::HEAD_NORTH;
		end else if (s_acc) begin
			cur_x_q   <= nx;
			cur_y_q   <= ny;
			heading_q <= h_next;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_acc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			out_action_q  <= act;
			out_x_q       <= nx_ext[3:0];
			out_y_q       <= ny_ext[3:0];
			out_heading_q <= h_next;
			out_walls_q   <= cell_new;
			out_goal_q    <= at_goal;
			out_off_q     <= off;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_off_q, out_goal_q, out_walls_q, out_heading_q,
		out_y_q, out_x_q, out_action_q};

`ifndef NO_ASSERTIONS
	// No item may enter while the map is still being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !s_tready)
		else $error("input accepted during map clearing");

	// Standing on the goal freezes position and heading.
	a_goal_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && at_goal) |=> (cur_x_q == $past(cur_x_q) && cur_y_q == $past(cur_y_q)
			&& heading_q == $past(heading_q)))
		else $error("robot moved while at goal");

	// A step that stays on the grid always changes the position.
	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !at_goal && !off) |=> (cur_x_q != $past(cur_x_q)
			|| cur_y_q != $past(cur_y_q)))
		else $error("step taken without a position change");
`endif

endmodule

[dv/maze_wall_follower_step_test.sv]
`timescale 1ns / 100ps

module maze_wall_follower_step_test;

	localparam int GRID_SIDE = 16;
	localparam int STEP_ITEMS = 1900;
	localparam int CYCLE_LIMIT = 300000;

	// One expected move, field by field as it leaves the block.
	typedef struct {
		mwf_pkg::action_t action;
		logic [3:0]       pos_x;
		logic [3:0]       pos_y;
		logic [1:0]       heading;
		logic [3:0]       cell_walls;
		logic             at_goal;
		logic             off_grid;
	} move_result_t;

	// Tracks the robot and its wall map, and checks each reported move.
	class move_scoreboard;
		logic [3:0]   goal_x = 4'd0;
		logic [3:0]   goal_y = 4'd0;
		logic         follow_right = 1'b1;
		logic [1:0]   head = mwf_pkg::HEAD_NORTH;
		logic [3:0]   pos_x = 4'd0;
		logic [3:0]   pos_y = 4'd0;
		logic [3:0]   wall_map [GRID_SIDE*GRID_SIDE];
		move_result_t pending_moves [$];
		int           mismatch_count = 0;

		function new();
			foreach (wall_map[i])
				wall_map[i] = 4'd0;
		endfunction

		function void set_goal(logic [3:0] gx, logic [3:0] gy, logic fr);
			goal_x = gx;
			goal_y = gy;
			follow_right = fr;
		endfunction

		// Records the sensed walls, decides the move and queues the expected result.
		function void take_sensors(logic [2:0] sense);
			move_result_t mv;
			logic         wl;
			logic         wf;
			logic         wr;
			logic [1:0]   lside;
			logic [1:0]   rside;
			logic [3:0]   walls;
			int           cell_idx;
			wl = sense[0];
			wf = sense[1];
			wr = sense[2];
			lside = head + 2'd3;
			rside = head + 2'd1;
			cell_idx = int'(pos_y) * GRID_SIDE + int'(pos_x);
			walls = wall_map[cell_idx];
			if (wf)
				walls[head] = 1'b1;
			if (wl)
				walls[lside] = 1'b1;
			if (wr)
				walls[rside] = 1'b1;
			wall_map[cell_idx] = walls;
			mv.cell_walls = walls;
			mv.at_goal = 1'b0;
			mv.off_grid = 1'b0;
			if (pos_x == goal_x && pos_y == goal_y) begin
				mv.at_goal = 1'b1;
				mv.action = mwf_pkg::ACT_STOP;
			end else begin
				if (follow_right) begin
					if (!wr) mv.action = mwf_pkg::ACT_RIGHT;
					else if (!wf) mv.action = mwf_pkg::ACT_FWD;
					else if (!wl) mv.action = mwf_pkg::ACT_LEFT;
					else mv.action = mwf_pkg::ACT_BACK;
				end else begin
					if (!wl) mv.action = mwf_pkg::ACT_LEFT;
					else if (!wf) mv.action = mwf_pkg::ACT_FWD;
					else if (!wr) mv.action = mwf_pkg::ACT_RIGHT;
					else mv.action = mwf_pkg::ACT_BACK;
				end
				case (mv.action)
					mwf_pkg::ACT_LEFT:  head = head + 2'd3;
					mwf_pkg::ACT_RIGHT: head = head + 2'd1;
					mwf_pkg::ACT_BACK:  head = head + 2'd2;
					default:            head = head;
				endcase
				// The step is held at the border, but the turn still counts.
				case (head)
					mwf_pkg::HEAD_NORTH: begin
						if (int'(pos_y) < GRID_SIDE - 1) pos_y = pos_y + 4'd1;
						else mv.off_grid = 1'b1;
					end
					mwf_pkg::HEAD_EAST: begin
						if (int'(pos_x) < GRID_SIDE - 1) pos_x = pos_x + 4'd1;
						else mv.off_grid = 1'b1;
					end
					mwf_pkg::HEAD_SOUTH: begin
						if (pos_y != 4'd0) pos_y = pos_y - 4'd1;
						else mv.off_grid = 1'b1;
					end
					default: begin
						if (pos_x != 4'd0) pos_x = pos_x - 4'd1;
						else mv.off_grid = 1'b1;
					end
				endcase
			end
			mv.pos_x = pos_x;
			mv.pos_y = pos_y;
			mv.heading = head;
			pending_moves.push_back(mv);
		endfunction

		task flag_mismatch(string field, int got, int want);
			$display("%0t: move mismatch on %s: got %0d, expected %0d",
				$realtime, field, got, want);
			mismatch_count++;
		endtask

		// Compares one output transaction with the oldest queued move.
		task check_move(logic [23:0] word);
			move_result_t want;
			if (pending_moves.size() == 0) begin
				flag_mismatch("unexpected result", int'(word), 0);
				return;
			end
			want = pending_moves.pop_front();
			if (word[2:0] !== want.action)
				flag_mismatch("action", word[2:0], want.action);
			if (word[6:3] !== want.pos_x)
				flag_mismatch("pos_x", word[6:3], want.pos_x);
			if (word[10:7] !== want.pos_y)
				flag_mismatch("pos_y", word[10:7], want.pos_y);
			if (word[12:11] !== want.heading)
				flag_mismatch("heading", word[12:11], want.heading);
			if (word[16:13] !== want.cell_walls)
				flag_mismatch("cell_walls", word[16:13], want.cell_walls);
			if (word[17] !== want.at_goal)
				flag_mismatch("at_goal", word[17], want.at_goal);
			if (word[18] !== want.off_grid)
				flag_mismatch("off_grid", word[18], want.off_grid);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [0] sense_left, [1] sense_front, [2] sense_right, [7:3] zero
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [2:0] action, [6:3] pos_x, [10:7] pos_y, [12:11] heading,
	// [16:13] cell_walls, [17] at_goal, [18] off_grid, [23:19] zero
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = mwf_pkg::CFG_GOAL_X;
	logic [3:0]  cfg_data = 4'd0;

	move_scoreboard sb = new();

	bit tx_busy = 1'b0;
	int rx_hold = 0;
	int cycle_count = 0;

	maze_wall_follower_step #(
		.GRID_SIDE(GRID_SIDE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Check every output transaction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_move(m_tdata);
	end

	// Receiver: random stalls with quiet stretches, and one long hold-off on request.
	initial begin
		int  stall;
		bit  rx_busy;
		rx_busy = 1'b1;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_busy = !rx_busy;
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end else begin
				stall = rx_busy ? $urandom_range(0, 5) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// Offers one sensor transaction and notes it once it is taken.
	task offer_sensors(logic [2:0] sense);
		int gap;
		gap = tx_busy ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, sense};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_sensors(sense);
	endtask

	// Stops offering and waits until every queued move has been reported.
	task drain_moves();
		s_tvalid <= 1'b0;
		while (sb.pending_moves.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes all three registers; only called while the block is idle.
	task program_goal(logic [3:0] gx, logic [3:0] gy, logic fr);
		cfg_we <= 1'b1;
		cfg_index <= mwf_pkg::CFG_GOAL_X;
		cfg_data <= gx;
		@(posedge clk);
		cfg_index <= mwf_pkg::CFG_GOAL_Y;
		cfg_data <= gy;
		@(posedge clk);
		cfg_index <= mwf_pkg::CFG_FOLLOW_RIGHT;
		cfg_data <= {3'd0, fr};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_goal(gx, gy, fr);
	endtask

	// Mostly readings that agree with walls already known, plus fresh walls;
	// noisy phases use plain random readings.
	function automatic logic [2:0] next_sensors(bit noisy);
		logic [3:0] known;
		logic [1:0] lside;
		logic [1:0] rside;
		logic [2:0] sense;
		if (noisy)
			return 3'($urandom_range(0, 7));
		known = sb.wall_map[int'(sb.pos_y) * GRID_SIDE + int'(sb.pos_x)];
		lside = sb.head + 2'd3;
		rside = sb.head + 2'd1;
		sense[0] = known[lside] | ($urandom_range(0, 3) == 0);
		sense[1] = known[sb.head] | ($urandom_range(0, 3) == 0);
		sense[2] = known[rside] | ($urandom_range(0, 3) == 0);
		return sense;
	endfunction

	function automatic logic [3:0] near_coord(logic [3:0] c);
		int v;
		v = int'(c) + $urandom_range(0, 6) - 3;
		if (v < 0)
			v = 0;
		if (v > GRID_SIDE - 1)
			v = GRID_SIDE - 1;
		return 4'(v);
	endfunction

	initial begin
		int         fed;
		int         phase;
		int         mode;
		int         len;
		bit         noisy;
		logic [3:0] gx;
		logic [3:0] gy;
		fed = 0;
		phase = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The reset goal is the start cell: walls are still recorded on a stop.
		offer_sensors(3'b111);
		offer_sensors(3'b000);
		offer_sensors(3'b010);
		drain_moves();

		// Every sensor combination under both follow modes, starting at a corner.
		for (int fr = 0; fr < 2; fr++) begin
			program_goal(4'd15, 4'd15, fr[0]);
			for (int c = 0; c < 8; c++)
				offer_sensors(c[2:0]);
			drain_moves();
		end

		// Random phases with a fresh goal and follow mode each.
		while (fed < STEP_ITEMS) begin
			phase++;
			mode = $urandom_range(0, 5);
			len = $urandom_range(30, 90);
			case (mode)
				0: begin
					// Goal on the current cell: stops from the first item.
					gx = sb.pos_x;
					gy = sb.pos_y;
					len = 4;
				end
				1: begin
					gx = $urandom_range(0, 1) ? 4'd15 : 4'd0;
					gy = $urandom_range(0, 1) ? 4'd15 : 4'd0;
				end
				2, 3: begin
					gx = near_coord(sb.pos_x);
					gy = near_coord(sb.pos_y);
				end
				default: begin
					gx = 4'($urandom_range(0, 15));
					gy = 4'($urandom_range(0, 15));
				end
			endcase
			program_goal(gx, gy, 1'($urandom_range(0, 1)));
			tx_busy = $urandom_range(0, 3) != 0;
			noisy = $urandom_range(0, 3) == 0;
			if (phase == 3) begin
				// Long receiver hold-off while the sender keeps offering.
				rx_hold = 300;
				tx_busy = 1'b0;
				len = 90;
			end
			repeat (len) begin
				offer_sensors(next_sensors(noisy));
				fed++;
			end
			drain_moves();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
rtl/mwf_pkg.sv
rtl/mwf_wall_mem.sv
rtl/maze_wall_follower_step.sv
dv/maze_wall_follower_step_test.sv
